// File: rtl/dlr_pkg.sv
package dlr_pkg;

   // Coordinate width used inside the block; port fields stay at the full width.
   localparam int COORD_BITS     = 6;
   localparam int PORT_COORD_BITS = 6;
   localparam int GRAY_BITS      = 8;

   // Line descriptor queue between the front and back parts.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   // One classified line: start point, per-axis magnitude and direction,
   // the step count n = max(|dx|, |dy|) and the gray level.
   typedef struct packed {
      coord_type            x_start;
      coord_type            y_start;
      coord_type            x_mag;
      coord_type            y_mag;
      coord_type            steps;
      logic                 x_neg;
      logic                 y_neg;
      logic [GRAY_BITS-1:0] gray;
   } line_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

// File: rtl/dlr_front.sv
module dlr_front import dlr_pkg::*; (
   input  logic [PORT_COORD_BITS-1:0] req_x_start,
   input  logic [PORT_COORD_BITS-1:0] req_y_start,
   input  logic [PORT_COORD_BITS-1:0] req_x_end,
   input  logic [PORT_COORD_BITS-1:0] req_y_end,
   input  logic [GRAY_BITS-1:0]       req_gray,
   output line_desc_type              desc
);

   coord_type xs;
   coord_type ys;
   coord_type xe;
   coord_type ye;
   coord_type x_mag;
   coord_type y_mag;
   logic      x_neg;
   logic      y_neg;

   // Bits above the coordinate width are ignored.
   assign xs = req_x_start[COORD_BITS-1:0];
   assign ys = req_y_start[COORD_BITS-1:0];
   assign xe = req_x_end[COORD_BITS-1:0];
   assign ye = req_y_end[COORD_BITS-1:0];

   always_comb begin
      x_neg = (xe < xs);
      y_neg = (ye < ys);
      x_mag = x_neg ? (xs - xe) : (xe - xs);
      y_mag = y_neg ? (ys - ye) : (ye - ys);
   end

   always_comb begin
      desc.x_start = xs;
      desc.y_start = ys;
      desc.x_mag   = x_mag;
      desc.y_mag   = y_mag;
      desc.steps   = (x_mag > y_mag) ? x_mag : y_mag;
      desc.x_neg   = x_neg;
      desc.y_neg   = y_neg;
      desc.gray    = req_gray;
   end

endmodule

// File: rtl/dlr_queue.sv
module dlr_queue import dlr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  line_desc_type    push_desc,
   input  logic             pop,
   output line_desc_type    head_desc,
   output queue_status_type status
);

   line_desc_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff;
   logic [QUEUE_CNT_BITS-1:0]   count_in;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("line queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("line queue read while empty");
`endif

endmodule

// File: rtl/dlr_back.sv
module dlr_back import dlr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  queue_status_type           queue_status,
   input  line_desc_type              head_desc,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_x,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_y,
   output logic [GRAY_BITS-1:0]       rsp_pixel_gray,
   output logic                       rsp_last
);

   back_state_type  state_ff;
   back_state_type  state_in;
   line_desc_type   desc_ff;
   coord_type       step_ff;
   coord_type       step_in;
   coord_type       qx_ff;
   coord_type       qx_in;
   coord_type       rx_ff;
   coord_type       rx_in;
   coord_type       qy_ff;
   coord_type       qy_in;
   coord_type       ry_ff;
   coord_type       ry_in;

   logic            running;
   logic            final_step;
   logic            load;
   logic [COORD_BITS:0] rx_sum;
   logic [COORD_BITS:0] ry_sum;
   logic [COORD_BITS:0] rx_sub;
   logic [COORD_BITS:0] ry_sub;
   logic            x_wrap;
   logic            y_wrap;
   coord_type       pix_x;
   coord_type       pix_y;

   logic                       rsp_valid_ff;
   logic [PORT_COORD_BITS-1:0] rsp_x_ff;
   logic [PORT_COORD_BITS-1:0] rsp_y_ff;
   logic [GRAY_BITS-1:0]       rsp_gray_ff;
   logic                       rsp_last_ff;

   assign running    = (state_ff == BACK_RUN);
   assign final_step = (step_ff == desc_ff.steps);

   // Next state.
   always_comb begin
      case (state_ff)
         BACK_IDLE: state_in = queue_status.empty ? BACK_IDLE : BACK_RUN;
         BACK_RUN:  state_in = (final_step && queue_status.empty) ? BACK_IDLE : BACK_RUN;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // State outputs: take a new line when idle or on the last pixel of the current one.
   always_comb begin
      case (state_ff)
         BACK_IDLE: load = !queue_status.empty;
         BACK_RUN:  load = final_step && !queue_status.empty;
         default:   load = 1'b0;
      endcase
   end

   assign pop = load;

   // Remainder update: r + m stays below 2n, so one compare and subtract suffices.
   always_comb begin
      rx_sum = {1'b0, rx_ff} + {1'b0, desc_ff.x_mag};
      ry_sum = {1'b0, ry_ff} + {1'b0, desc_ff.y_mag};
      rx_sub = rx_sum - {1'b0, desc_ff.steps};
      ry_sub = ry_sum - {1'b0, desc_ff.steps};
      x_wrap = (rx_sum >= {1'b0, desc_ff.steps});
      y_wrap = (ry_sum >= {1'b0, desc_ff.steps});
   end

   always_comb begin
      step_in = step_ff;
      qx_in   = qx_ff;
      rx_in   = rx_ff;
      qy_in   = qy_ff;
      ry_in   = ry_ff;
      if (load) begin
         step_in = '0;
         qx_in   = '0;
         rx_in   = '0;
         qy_in   = '0;
         ry_in   = '0;
      end else if (running) begin
         step_in = step_ff + 1'b1;
         qx_in   = x_wrap ? qx_ff + 1'b1 : qx_ff;
         rx_in   = x_wrap ? rx_sub[COORD_BITS-1:0] : rx_sum[COORD_BITS-1:0];
         qy_in   = y_wrap ? qy_ff + 1'b1 : qy_ff;
         ry_in   = y_wrap ? ry_sub[COORD_BITS-1:0] : ry_sum[COORD_BITS-1:0];
      end
   end

   // A negative direction floors away from the start, so a nonzero remainder adds one.
   always_comb begin
      if (desc_ff.x_neg) begin
         pix_x = desc_ff.x_start - qx_ff - COORD_BITS'(rx_ff != '0);
      end else begin
         pix_x = desc_ff.x_start + qx_ff;
      end
      if (desc_ff.y_neg) begin
         pix_y = desc_ff.y_start - qy_ff - COORD_BITS'(ry_ff != '0);
      end else begin
         pix_y = desc_ff.y_start + qy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= running;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      qx_ff   <= qx_in;
      rx_ff   <= rx_in;
      qy_ff   <= qy_in;
      ry_ff   <= ry_in;
      if (load) begin
         desc_ff <= head_desc;
      end
      rsp_x_ff    <= PORT_COORD_BITS'(pix_x);
      rsp_y_ff    <= PORT_COORD_BITS'(pix_y);
      rsp_gray_ff <= desc_ff.gray;
      rsp_last_ff <= final_step;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_pixel_gray = rsp_gray_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (step_ff <= desc_ff.steps))
      else $error("step counter ran past the end of the line");

   a_remainder_below_steps: assert property (@(posedge clock) disable iff (reset)
      (running && desc_ff.steps != '0) |-> (rx_ff < desc_ff.steps && ry_ff < desc_ff.steps))
      else $error("step remainder not reduced");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (running && final_step && queue_status.empty) |=> !running)
      else $error("back part kept running after the last pixel");
`endif

endmodule

// File: rtl/dda_line_rasterizer.sv
// Channel   Direction  Handshake             Payload
// request   in         start & !busy         req_x_start, req_y_start, req_x_end, req_y_end,
//                                            req_gray
// response  out        rsp_valid (one cycle) rsp_pixel_x, rsp_pixel_y, rsp_pixel_gray, rsp_last
//
// A line of n = max(|dx|, |dy|) steps produces n + 1 pixels, one per clock cycle, set by the
// single add-and-compare stepper in the back part. Each request passes the queue, the
// descriptor register and the response register; queued lines follow with no gap.
// Reset is synchronous and active high; it empties the descriptor queue and idles the stepper.
// busy is high while the two-entry descriptor queue is full. The receiver cannot stall.
module dda_line_rasterizer import dlr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [PORT_COORD_BITS-1:0] req_x_start,
   input  logic [PORT_COORD_BITS-1:0] req_y_start,
   input  logic [PORT_COORD_BITS-1:0] req_x_end,
   input  logic [PORT_COORD_BITS-1:0] req_y_end,
   input  logic [GRAY_BITS-1:0]       req_gray,
   output logic                       rsp_valid,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_x,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_y,
   output logic [GRAY_BITS-1:0]       rsp_pixel_gray,
   output logic                       rsp_last
);

   // The front part classifies each request into a line descriptor: masked start point,
   // per-axis distance and direction, and the step count.
   line_desc_type    front_desc;
   line_desc_type    head_desc;
   queue_status_type queue_status;
   logic             push;
   logic             pop;

   dlr_front u_front (
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_gray    (req_gray),
      .desc        (front_desc)
   );

   // A request transaction is taken whenever the queue has room.
   assign busy = queue_status.full;
   assign push = start && !queue_status.full;

   // The queue lets the front keep taking requests while the back part draws a line.
   dlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (front_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (queue_status)
   );

   // The back part walks the line with an exact floor: per axis it keeps the quotient and
   // remainder of i * |d| / n, updated by one add and compare each step, so no divider is
   // needed.
   dlr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .head_desc      (head_desc),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_gray (rsp_pixel_gray),
      .rsp_last       (rsp_last)
   );

endmodule
